@@ rtl/rgbgr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rgbgr_pkg
// Shared types, constants and the control store of the gradient run generator.
// ----------------------------------------------------------------------------
package rgbgr_pkg;

	localparam int COLOR_W    = 8;
	localparam int COUNT_W    = 6;
	localparam int DIV_CNT_W  = $clog2(COLOR_W);
	localparam int PC_W       = 4;
	localparam int CHAN_W     = 2;
	localparam int MAX_COLORS = 63;

	localparam logic [CHAN_W-1:0] CH_RED   = 2'd0;
	localparam logic [CHAN_W-1:0] CH_GREEN = 2'd1;
	localparam logic [CHAN_W-1:0] CH_BLUE  = 2'd2;

	typedef struct packed {
		logic [COLOR_W-1:0] base_red;
		logic [COLOR_W-1:0] base_green;
		logic [COLOR_W-1:0] base_blue;
		logic [COLOR_W-1:0] target_red;
		logic [COLOR_W-1:0] target_green;
		logic [COLOR_W-1:0] target_blue;
		logic [COUNT_W-1:0] count;
		logic               mirror;
	} req_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic [COUNT_W-1:0] position;
		logic               last;
	} res_t;

	typedef struct packed {
		logic init;
		logic step;
	} div_ctrl_t;

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_SETUP,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_END,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		CND_NEXT,
		CND_JUMP,
		CND_WAIT_IN,
		CND_EMPTY,
		CND_DIV_LOOP,
		CND_EMIT_LOOP
	} cond_t;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [CHAN_W-1:0] chan;
		logic [PC_W-1:0]   target;
	} ucode_t;

	localparam logic [PC_W-1:0] PC_START = 4'd0;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{OP_IDLE, CND_JUMP, CH_RED, PC_START};
		unique case (pc)
			4'd0:  w = '{OP_IDLE,     CND_WAIT_IN,   CH_RED,   PC_START};
			4'd1:  w = '{OP_SETUP,    CND_EMPTY,     CH_RED,   PC_START};
			4'd2:  w = '{OP_DIV_INIT, CND_NEXT,      CH_RED,   PC_START};
			4'd3:  w = '{OP_DIV_STEP, CND_DIV_LOOP,  CH_RED,   PC_START};
			4'd4:  w = '{OP_DIV_END,  CND_NEXT,      CH_RED,   PC_START};
			4'd5:  w = '{OP_DIV_INIT, CND_NEXT,      CH_GREEN, PC_START};
			4'd6:  w = '{OP_DIV_STEP, CND_DIV_LOOP,  CH_GREEN, PC_START};
			4'd7:  w = '{OP_DIV_END,  CND_NEXT,      CH_GREEN, PC_START};
			4'd8:  w = '{OP_DIV_INIT, CND_NEXT,      CH_BLUE,  PC_START};
			4'd9:  w = '{OP_DIV_STEP, CND_DIV_LOOP,  CH_BLUE,  PC_START};
			4'd10: w = '{OP_DIV_END,  CND_NEXT,      CH_BLUE,  PC_START};
			4'd11: w = '{OP_EMIT,     CND_EMIT_LOOP, CH_RED,   PC_START};
			default: w = '{OP_IDLE, CND_JUMP, CH_RED, PC_START};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

@@ rtl/rgbgr_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rgbgr_if
// Valid/ready channels for requests and gradient colors.
// ----------------------------------------------------------------------------
interface rgbgr_req_if;
	logic              valid;
	logic              ready;
	rgbgr_pkg::req_t   data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface rgbgr_res_if;
	logic              valid;
	logic              ready;
	rgbgr_pkg::res_t   data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/rgbgr_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rgbgr_div
// Restoring divider, one quotient bit per step, unsigned magnitude only.
// ----------------------------------------------------------------------------
module rgbgr_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire rgbgr_pkg::div_ctrl_t              ctrl,
	input  wire logic [rgbgr_pkg::COLOR_W-1:0]     dividend,
	input  wire logic [rgbgr_pkg::COUNT_W-1:0]     divisor,
	output logic      [rgbgr_pkg::COLOR_W-1:0]     quotient,
	output logic                                   done
);
	logic [rgbgr_pkg::COLOR_W-1:0]   quo_q;
	logic [rgbgr_pkg::COUNT_W-1:0]   rem_q;
	logic [rgbgr_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [rgbgr_pkg::COUNT_W:0]     trial;
	logic [rgbgr_pkg::COUNT_W:0]     diff;
	logic                            fits;

	assign trial = {rem_q, quo_q[rgbgr_pkg::COLOR_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.init) begin
			cnt_q <= '0;
		end else if (ctrl.step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (ctrl.step) begin
			quo_q <= {quo_q[rgbgr_pkg::COLOR_W-2:0], fits};
			rem_q <= fits ? diff[rgbgr_pkg::COUNT_W-1:0] : trial[rgbgr_pkg::COUNT_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = (cnt_q == {rgbgr_pkg::DIV_CNT_W{1'b1}});
endmodule
`default_nettype wire

@@ rtl/rgb_gradient_run_generator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_gradient_run_generator: linear RGB gradient run from one request beat.
// The first color is offered once all three channel divisions are done; then one color
// per cycle while rsp.ready stays high.
// An empty run returns to idle after setup; the block takes one request at a time.
// Each channel's step comes from the 8-step serial divider shared by the three channels.
// Reset clears the sequencer and divider step count; a request is taken right after reset.
// ----------------------------------------------------------------------------
module rgb_gradient_run_generator #(
	parameter int MAX_COLORS = rgbgr_pkg::MAX_COLORS
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rgbgr_req_if.sink  req,
	rgbgr_res_if.source rsp
);
	localparam int CW = rgbgr_pkg::COLOR_W;
	localparam int NW = rgbgr_pkg::COUNT_W;
	localparam logic [7:0] MaxC = 8'(MAX_COLORS);

	logic [rgbgr_pkg::PC_W-1:0] pc_q;
	logic [rgbgr_pkg::PC_W-1:0] pc_nxt;
	rgbgr_pkg::ucode_t          uw;

	logic [CW-1:0]        base_q [3];
	logic [CW-1:0]        target_q [3];
	logic                 mirror_q;
	logic [NW-1:0]        n_q;
	logic [NW-1:0]        emit_q;
	logic [NW-1:0]        k_q;
	logic [CW-1:0]        acc_q [3];
	logic signed [CW:0]   step_q [3];
	logic                 neg_q;

	logic                 req_fire;
	logic                 rsp_fire;
	logic                 is_last;
	logic [NW-1:0]        half;
	logic [NW-1:0]        total;
	logic [NW-1:0]        emit_d;
	logic [CW-1:0]        b_sel;
	logic [CW-1:0]        t_sel;
	logic signed [CW:0]   diff;
	logic [CW-1:0]        mag;
	logic [CW-1:0]        quo;
	logic                 div_done;
	rgbgr_pkg::div_ctrl_t div_ctrl;
	logic                 rising;

	assign uw = rgbgr_pkg::ucode_rom(pc_q);

	assign req.ready = (uw.op == rgbgr_pkg::OP_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign rsp.valid = (uw.op == rgbgr_pkg::OP_EMIT);
	assign rsp_fire  = rsp.valid && rsp.ready;
	assign is_last   = (k_q == emit_q - 1'b1);

	// request decode
	assign half   = {1'b0, req.data.count[NW-1:1]};
	assign total  = req.data.mirror ? {req.data.count[NW-1:1], 1'b1} : req.data.count;
	assign emit_d = ({2'b00, total} > MaxC) ? MaxC[NW-1:0] : total;

	// divider operand selection
	assign b_sel = base_q[uw.chan];
	assign t_sel = target_q[uw.chan];
	assign diff  = $signed({1'b0, t_sel}) - $signed({1'b0, b_sel});
	assign mag   = diff[CW] ? CW'(-diff) : diff[CW-1:0];

	assign div_ctrl.init = (uw.op == rgbgr_pkg::OP_DIV_INIT);
	assign div_ctrl.step = (uw.op == rgbgr_pkg::OP_DIV_STEP);

	rgbgr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (mag),
		.divisor  (n_q),
		.quotient (quo),
		.done     (div_done)
	);

	// sequencer
	always_comb begin
		pc_nxt = pc_q + 1'b1;
		unique case (uw.cond)
			rgbgr_pkg::CND_NEXT:      pc_nxt = pc_q + 1'b1;
			rgbgr_pkg::CND_JUMP:      pc_nxt = uw.target;
			rgbgr_pkg::CND_WAIT_IN:   pc_nxt = req_fire ? pc_q + 1'b1 : pc_q;
			rgbgr_pkg::CND_EMPTY:     pc_nxt = (emit_q == '0) ? uw.target : pc_q + 1'b1;
			rgbgr_pkg::CND_DIV_LOOP:  pc_nxt = div_done ? pc_q + 1'b1 : pc_q;
			rgbgr_pkg::CND_EMIT_LOOP: pc_nxt = (rsp_fire && is_last) ? uw.target : pc_q;
			default:                  pc_nxt = rgbgr_pkg::PC_START;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= rgbgr_pkg::PC_START;
		end else begin
			pc_q <= pc_nxt;
		end
	end

	// datapath
	assign rising = !mirror_q || (k_q < n_q);

	always_ff @(posedge clk) begin
		if (req_fire) begin
			base_q[0]   <= req.data.base_red;
			base_q[1]   <= req.data.base_green;
			base_q[2]   <= req.data.base_blue;
			target_q[0] <= req.data.target_red;
			target_q[1] <= req.data.target_green;
			target_q[2] <= req.data.target_blue;
			mirror_q    <= req.data.mirror;
			n_q         <= req.data.mirror ? half : req.data.count;
			emit_q      <= emit_d;
		end
		if (uw.op == rgbgr_pkg::OP_SETUP) begin
			k_q <= '0;
			for (int c = 0; c < 3; c++) begin
				acc_q[c] <= base_q[c];
			end
		end
		if (div_ctrl.init) begin
			neg_q <= diff[CW];
		end
		if (uw.op == rgbgr_pkg::OP_DIV_END) begin
			if (n_q == '0) begin
				step_q[uw.chan] <= '0;
			end else begin
				step_q[uw.chan] <= neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
			end
		end
		if (rsp_fire) begin
			k_q <= k_q + 1'b1;
			for (int c = 0; c < 3; c++) begin
				acc_q[c] <= rising ? acc_q[c] + step_q[c][CW-1:0]
				                   : acc_q[c] - step_q[c][CW-1:0];
			end
		end
	end

	assign rsp.data.red      = acc_q[0];
	assign rsp.data.green    = acc_q[1];
	assign rsp.data.blue     = acc_q[2];
	assign rsp.data.position = k_q;
	assign rsp.data.last     = is_last;
endmodule
`default_nettype wire
